FILE: hdl/cau_pkg.sv
// Shared operation codes for the complex arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
package cau_pkg;
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;
endpackage
`default_nettype wire

FILE: hdl/cau_div.sv
// Pipelined restoring divider for the real and imaginary quotients, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cau_div #(
	parameter int W         = 32,
	parameter int F         = 16,
	parameter int SIDE_BITS = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [2*W-1:0]       in_den,
	input  wire logic [2*W-1:0]       in_mag_re,
	input  wire logic                 in_neg_re,
	input  wire logic [2*W-1:0]       in_mag_im,
	input  wire logic                 in_neg_im,
	input  wire logic [SIDE_BITS-1:0] in_side,
	output logic                      out_valid,
	output logic [W:0]                out_q_re,
	output logic                      out_pre_re,
	output logic                      out_neg_re,
	output logic [W:0]                out_q_im,
	output logic                      out_pre_im,
	output logic                      out_neg_im,
	output logic [SIDE_BITS-1:0]      out_side
);
	localparam int NW = 2*W + F;
	localparam int PW = W + F - 1;
	localparam int CW = (PW > 2*W) ? PW : 2*W;
	localparam int STEPS = W + 1;

	logic [NW-1:0] n_re;
	logic [NW-1:0] n_im;
	logic [PW-1:0] p_re;
	logic [PW-1:0] p_im;

	logic                 v_s    [0:STEPS];
	logic [2*W-1:0]       den_s  [0:STEPS];
	logic [2*W-1:0]       rre_s  [0:STEPS];
	logic [2*W-1:0]       rim_s  [0:STEPS];
	logic [W:0]           lre_s  [0:STEPS];
	logic [W:0]           lim_s  [0:STEPS];
	logic [W:0]           qre_s  [0:STEPS];
	logic [W:0]           qim_s  [0:STEPS];
	logic                 pre_s  [0:STEPS];
	logic                 pim_s  [0:STEPS];
	logic                 nre_s  [0:STEPS];
	logic                 nim_s  [0:STEPS];
	logic [SIDE_BITS-1:0] side_s [0:STEPS];

	assign n_re = NW'(in_mag_re) << F;
	assign n_im = NW'(in_mag_im) << F;
	assign p_re = n_re[NW-1:W+1];
	assign p_im = n_im[NW-1:W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		den_s[0]  <= in_den;
		rre_s[0]  <= (2*W)'(p_re);
		rim_s[0]  <= (2*W)'(p_im);
		lre_s[0]  <= n_re[W:0];
		lim_s[0]  <= n_im[W:0];
		qre_s[0]  <= '0;
		qim_s[0]  <= '0;
		pre_s[0]  <= (CW'(p_re) >= CW'(in_den));
		pim_s[0]  <= (CW'(p_im) >= CW'(in_den));
		nre_s[0]  <= in_neg_re;
		nim_s[0]  <= in_neg_im;
		side_s[0] <= in_side;
	end

	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [2*W:0] t_re;
		logic [2*W:0] t_im;
		logic [2*W:0] d_re;
		logic [2*W:0] d_im;
		logic         ge_re;
		logic         ge_im;

		assign t_re  = {rre_s[k-1], lre_s[k-1][W]};
		assign t_im  = {rim_s[k-1], lim_s[k-1][W]};
		assign d_re  = t_re - {1'b0, den_s[k-1]};
		assign d_im  = t_im - {1'b0, den_s[k-1]};
		assign ge_re = !d_re[2*W];
		assign ge_im = !d_im[2*W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k]  <= den_s[k-1];
			rre_s[k]  <= ge_re ? d_re[2*W-1:0] : t_re[2*W-1:0];
			rim_s[k]  <= ge_im ? d_im[2*W-1:0] : t_im[2*W-1:0];
			lre_s[k]  <= {lre_s[k-1][W-1:0], 1'b0};
			lim_s[k]  <= {lim_s[k-1][W-1:0], 1'b0};
			qre_s[k]  <= {qre_s[k-1][W-1:0], ge_re};
			qim_s[k]  <= {qim_s[k-1][W-1:0], ge_im};
			pre_s[k]  <= pre_s[k-1];
			pim_s[k]  <= pim_s[k-1];
			nre_s[k]  <= nre_s[k-1];
			nim_s[k]  <= nim_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid  = v_s[STEPS];
	assign out_q_re   = qre_s[STEPS];
	assign out_q_im   = qim_s[STEPS];
	assign out_pre_re = pre_s[STEPS];
	assign out_pre_im = pim_s[STEPS];
	assign out_neg_re = nre_s[STEPS];
	assign out_neg_im = nim_s[STEPS];
	assign out_side   = side_s[STEPS];
endmodule
`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
// Top level of the pipelined complex add, subtract, multiply and divide unit.
// Throughput: one transfer per cycle; busy stays low, since the receiver cannot stall.
// The divide path sets the depth: one quotient bit per stage over WORD_BITS + 1 stages.
// Reset clears all valid bits at once; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module complex_arithmetic_unit #(
	parameter int WORD_BITS     = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic signed [WORD_BITS-1:0] a_re,
	input  wire logic signed [WORD_BITS-1:0] a_im,
	input  wire logic signed [WORD_BITS-1:0] b_re,
	input  wire logic signed [WORD_BITS-1:0] b_im,
	output logic                             done,
	output logic signed [WORD_BITS-1:0]      res_re,
	output logic signed [WORD_BITS-1:0]      res_im,
	output logic                             overflow,
	output logic                             div_by_zero
);
	localparam int W = WORD_BITS;
	localparam int F = FRACTION_BITS;
	localparam int SIDE_BITS = 2*W + 3;
	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	logic                  v_s1;
	cau_pkg::op_t          op_s1;
	logic signed [W-1:0]   are_s1, aim_s1, bre_s1, bim_s1;

	logic                  v_s2;
	cau_pkg::op_t          op_s2;
	logic signed [2*W-1:0] prr_s2, pii_s2, pri_s2, pir_s2, pbr_s2, pbi_s2;
	logic signed [W:0]     sre_s2, sim_s2;

	logic                  v_s3;
	logic                  div_s3;
	logic [W-1:0]          rre_s3, rim_s3;
	logic                  ovf_s3;
	logic signed [2*W:0]   nre_s3, nim_s3;
	logic [2*W-1:0]        den_s3;

	logic                  v_s4;
	logic [2*W-1:0]        den_s4;
	logic [2*W-1:0]        mre_s4, mim_s4;
	logic                  gre_s4, gim_s4;
	logic [SIDE_BITS-1:0]  side_s4;

	logic signed [2*W:0]   mul_re, mul_im, shr_re, shr_im;
	logic [W-1:0]          s3_re, s3_im;
	logic                  s3_ovf;
	logic signed [2*W:0]   abs_re, abs_im;

	logic                  dv_valid;
	logic [W:0]            dq_re, dq_im;
	logic                  dpre_re, dpre_im, dneg_re, dneg_im;
	logic [SIDE_BITS-1:0]  dside;

	logic                  o_div, o_dz, o_ovf;
	logic [W-1:0]          o_re, o_im;
	logic                  big_re, big_im;
	logic [W-1:0]          qv_re, qv_im;
	logic [W-1:0]          f_re, f_im;
	logic                  f_ovf;

	logic                  done_q, ovf_q, dz_q;
	logic [W-1:0]          re_q, im_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= cau_pkg::op_t'(op);
		are_s1 <= a_re;
		aim_s1 <= a_im;
		bre_s1 <= b_re;
		bim_s1 <= b_im;
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		prr_s2 <= are_s1 * bre_s1;
		pii_s2 <= aim_s1 * bim_s1;
		pri_s2 <= are_s1 * bim_s1;
		pir_s2 <= aim_s1 * bre_s1;
		pbr_s2 <= bre_s1 * bre_s1;
		pbi_s2 <= bim_s1 * bim_s1;
		if (op_s1 == cau_pkg::OP_SUB) begin
			sre_s2 <= (W+1)'(are_s1) - (W+1)'(bre_s1);
			sim_s2 <= (W+1)'(aim_s1) - (W+1)'(bim_s1);
		end else begin
			sre_s2 <= (W+1)'(are_s1) + (W+1)'(bre_s1);
			sim_s2 <= (W+1)'(aim_s1) + (W+1)'(bim_s1);
		end
	end

	assign mul_re = (2*W+1)'(prr_s2) - (2*W+1)'(pii_s2);
	assign mul_im = (2*W+1)'(pri_s2) + (2*W+1)'(pir_s2);
	assign shr_re = mul_re >>> F;
	assign shr_im = mul_im >>> F;

	always_comb begin
		logic fit_re, fit_im;
		if (op_s2 == cau_pkg::OP_MUL) begin
			fit_re = (&shr_re[2*W:W-1]) || !(|shr_re[2*W:W-1]);
			fit_im = (&shr_im[2*W:W-1]) || !(|shr_im[2*W:W-1]);
			s3_re  = fit_re ? shr_re[W-1:0] : (shr_re[2*W] ? MIN_V : MAX_V);
			s3_im  = fit_im ? shr_im[W-1:0] : (shr_im[2*W] ? MIN_V : MAX_V);
		end else begin
			fit_re = (sre_s2[W] == sre_s2[W-1]);
			fit_im = (sim_s2[W] == sim_s2[W-1]);
			s3_re  = fit_re ? sre_s2[W-1:0] : (sre_s2[W] ? MIN_V : MAX_V);
			s3_im  = fit_im ? sim_s2[W-1:0] : (sim_s2[W] ? MIN_V : MAX_V);
		end
		s3_ovf = !fit_re || !fit_im;
	end

	always_ff @(posedge clk) begin
		div_s3 <= (op_s2 == cau_pkg::OP_DIV);
		rre_s3 <= s3_re;
		rim_s3 <= s3_im;
		ovf_s3 <= s3_ovf;
		nre_s3 <= (2*W+1)'(prr_s2) + (2*W+1)'(pii_s2);
		nim_s3 <= (2*W+1)'(pir_s2) - (2*W+1)'(pri_s2);
		den_s3 <= $unsigned(pbr_s2) + $unsigned(pbi_s2);
	end

	assign abs_re = nre_s3[2*W] ? -nre_s3 : nre_s3;
	assign abs_im = nim_s3[2*W] ? -nim_s3 : nim_s3;

	always_ff @(posedge clk) begin
		den_s4  <= den_s3;
		mre_s4  <= abs_re[2*W-1:0];
		mim_s4  <= abs_im[2*W-1:0];
		gre_s4  <= nre_s3[2*W];
		gim_s4  <= nim_s3[2*W];
		side_s4 <= {div_s3, (den_s3 == '0), ovf_s3, rre_s3, rim_s3};
	end

	cau_div #(
		.W         (W),
		.F         (F),
		.SIDE_BITS (SIDE_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v_s4),
		.in_den     (den_s4),
		.in_mag_re  (mre_s4),
		.in_neg_re  (gre_s4),
		.in_mag_im  (mim_s4),
		.in_neg_im  (gim_s4),
		.in_side    (side_s4),
		.out_valid  (dv_valid),
		.out_q_re   (dq_re),
		.out_pre_re (dpre_re),
		.out_neg_re (dneg_re),
		.out_q_im   (dq_im),
		.out_pre_im (dpre_im),
		.out_neg_im (dneg_im),
		.out_side   (dside)
	);

	assign {o_div, o_dz, o_ovf, o_re, o_im} = dside;

	always_comb begin
		if (dneg_re) begin
			big_re = dpre_re || dq_re[W] || (dq_re[W-1] && (|dq_re[W-2:0]));
			qv_re  = big_re ? MIN_V : -dq_re[W-1:0];
		end else begin
			big_re = dpre_re || dq_re[W] || dq_re[W-1];
			qv_re  = big_re ? MAX_V : dq_re[W-1:0];
		end
		if (dneg_im) begin
			big_im = dpre_im || dq_im[W] || (dq_im[W-1] && (|dq_im[W-2:0]));
			qv_im  = big_im ? MIN_V : -dq_im[W-1:0];
		end else begin
			big_im = dpre_im || dq_im[W] || dq_im[W-1];
			qv_im  = big_im ? MAX_V : dq_im[W-1:0];
		end
		if (!o_div) begin
			f_re  = o_re;
			f_im  = o_im;
			f_ovf = o_ovf;
		end else if (o_dz) begin
			f_re  = '0;
			f_im  = '0;
			f_ovf = 1'b0;
		end else begin
			f_re  = qv_re;
			f_im  = qv_im;
			f_ovf = big_re || big_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		re_q  <= f_re;
		im_q  <= f_im;
		ovf_q <= f_ovf;
		dz_q  <= o_div && o_dz;
	end

	assign done        = done_q;
	assign res_re      = re_q;
	assign res_im      = im_q;
	assign overflow    = ovf_q;
	assign div_by_zero = dz_q;

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
		else $error("division by zero result is not zero");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |-> res_re == MAX_V || res_re == MIN_V ||
			res_im == MAX_V || res_im == MIN_V)
		else $error("overflow flagged without a saturated part");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("pipeline lost a transfer");
`endif
endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the complex arithmetic unit with a built-in result predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               ovf;
		logic               dz;
	} cplx_res_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] op;
	logic signed [31:0] a_re, a_im, b_re, b_im;
	logic done;
	logic signed [31:0] res_re, res_im;
	logic overflow, div_by_zero;

	cplx_res_t pending_q[$];
	int errors;
	int idle_pct;

	complex_arithmetic_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
		.res_re(res_re), .res_im(res_im), .overflow(overflow), .div_by_zero(div_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("simulation failed");
		$finish;
	end

	function automatic logic signed [31:0] clamp32(input logic signed [159:0] v, inout logic ovf);
		if (v > 160'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end else if (v < -160'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic cplx_res_t predict_cplx(input cau_pkg::op_t code,
			input logic signed [31:0] ar, input logic signed [31:0] ai,
			input logic signed [31:0] br, input logic signed [31:0] bi);
		logic signed [159:0] xr, xi, yr, yi, re, im, den, nr, ni;
		cplx_res_t r;
		logic ovf;
		xr = ar;
		xi = ai;
		yr = br;
		yi = bi;
		ovf = 1'b0;
		r.dz = 1'b0;
		case (code)
			cau_pkg::OP_ADD: begin
				re = xr + yr;
				im = xi + yi;
			end
			cau_pkg::OP_SUB: begin
				re = xr - yr;
				im = xi - yi;
			end
			cau_pkg::OP_MUL: begin
				re = (xr * yr - xi * yi) >>> 16;
				im = (xr * yi + xi * yr) >>> 16;
			end
			default: begin
				den = yr * yr + yi * yi;
				if (den == 0) begin
					r.dz = 1'b1;
					re = 0;
					im = 0;
				end else begin
					nr = xr * yr + xi * yi;
					ni = xi * yr - xr * yi;
					re = (nr <<< 16) / den;
					im = (ni <<< 16) / den;
				end
			end
		endcase
		r.re = clamp32(re, ovf);
		r.im = clamp32(im, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	task automatic send_item(input cau_pkg::op_t code, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= code;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(predict_cplx(code, ar, ai, br, bi));
	endtask

	task automatic stop_sending();
		start <= 1'b0;
	endtask

	always @(posedge clk) begin
		cplx_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$error("result with no expectation: re=%h im=%h", res_re, res_im);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (res_re !== e.re) begin
					$error("res_re expected %h actual %h", e.re, res_re);
					errors++;
				end
				if (res_im !== e.im) begin
					$error("res_im expected %h actual %h", e.im, res_im);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow expected %b actual %b", e.ovf, overflow);
					errors++;
				end
				if (div_by_zero !== e.dz) begin
					$error("div_by_zero expected %b actual %b", e.dz, div_by_zero);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(131072) - 65536;
			3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] ext[5];
		ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000, 32'hffffffff};
		foreach (ext[i]) begin
			send_item(cau_pkg::OP_ADD, ext[i], ext[i], ext[i], ext[i]);
			send_item(cau_pkg::OP_SUB, ext[i], ext[(i + 1) % 5], ext[(i + 1) % 5], ext[i]);
			send_item(cau_pkg::OP_MUL, ext[i], ext[i], ext[(i + 1) % 5], ext[i]);
			send_item(cau_pkg::OP_DIV, ext[i], ext[(i + 2) % 5], ext[(i + 1) % 5], 32'h0);
		end
		send_item(cau_pkg::OP_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
		send_item(cau_pkg::OP_DIV, 32'h80000000, 32'h80000000, 32'h00000001, 32'h0);
		send_item(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_item(cau_pkg::OP_DIV, 32'h00030000, 32'hfffe0000, 32'h0, 32'h00020000);
	endtask

	task automatic test_random(input int n, input int pct);
		cau_pkg::op_t code;
		idle_pct = pct;
		repeat (n) begin
			code = cau_pkg::op_t'($urandom_range(3));
			send_item(code, rand_word(), rand_word(),
				($urandom_range(15) == 0) ? 32'h0 : rand_word(),
				($urandom_range(7) == 0) ? 32'h0 : rand_word());
		end
	endtask

	initial begin
		int wait_cycles;
		errors = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		op = cau_pkg::OP_ADD;
		a_re = '0;
		a_im = '0;
		b_re = '0;
		b_im = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 38);
		test_random(300, 88);
		test_random(300, 0);
		stop_sending();
		wait_cycles = 0;
		while (pending_q.size() != 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
